>>> src/ipid_pkg.sv
// shared constants, register indexes and duty lookup for the heater pid controller
`default_nettype none

package ipid_pkg;

  // fixed point and field widths
  localparam int FRAC_BITS = 10;
  localparam int TEMP_BITS = 10;

  localparam int TEMP_W   = 10;
  localparam int COEF_W   = 16;
  localparam int PERIOD_W = 8;
  localparam int DUTY_W   = 8;
  localparam int PWR_W    = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int ERR_W    = TEMP_W + 1;
  localparam int EFFORT_W = PWR_W + FRAC_BITS;
  localparam int PROD_W   = COEF_W + ERR_W;
  localparam int SUM_W    = PROD_W + 3;

  localparam int PCT_MAX  = 100;
  localparam int DUTY_MAX = 255;

  localparam logic [TEMP_W-1:0] TEMP_MASK = TEMP_W'((64'd1 << TEMP_BITS) - 64'd1);

  localparam logic signed [SUM_W-1:0] EFFORT_MAX_S = SUM_W'(PCT_MAX << FRAC_BITS);
  localparam logic [EFFORT_W-1:0]     EFFORT_MAX   = EFFORT_W'(PCT_MAX << FRAC_BITS);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_NOW   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_PREV  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_PREV2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD     = 3'd4;

  // register reset values
  localparam logic [TEMP_W-1:0]        SETPOINT_RST   = 10'd100;
  localparam logic signed [COEF_W-1:0] COEF_NOW_RST   = 16'sd1947;
  localparam logic signed [COEF_W-1:0] COEF_PREV_RST  = -16'sd3166;
  localparam logic signed [COEF_W-1:0] COEF_PREV2_RST = 16'sd1293;
  localparam logic [PERIOD_W-1:0]      PERIOD_RST     = 8'd10;

  // duty = trunc(power * 255 / 100), one entry per power code
  localparam int DUTY_LUT_N = 1 << PWR_W;
  localparam int DUTY_SEL_SHIFT = $clog2(DUTY_W);

  function automatic logic [DUTY_LUT_N*DUTY_W-1:0] build_duty_lut();
    logic [DUTY_LUT_N*DUTY_W-1:0] lut;
    lut = '0;
    for (int i = 0; i < DUTY_LUT_N; i++) begin
      lut[i*DUTY_W +: DUTY_W] = DUTY_W'((i * DUTY_MAX) / PCT_MAX);
    end
    return lut;
  endfunction

  localparam logic [DUTY_LUT_N*DUTY_W-1:0] DUTY_LUT = build_duty_lut();

endpackage

`default_nettype wire

>>> src/incremental_pid_heater_pwm.sv
// velocity-form pid heater controller with held pwm duty and power outputs
`default_nettype none

// usage
//   input channel (in_valid_i / in_ready_o) carries one tick item: a temperature
//   reading and the oven enable flag. every accepted item yields exactly one
//   result item on the output channel (out_valid_o / out_ready_i): the held
//   duty, the held power percent and a flag that marks ticks that ran an update.
//   a prescaler counts items; when it reaches the sample period the pid update
//   runs on the reading of the previous item, then this item's reading is kept.
//   an item enters the input register on acceptance and its result is
//   written to the output register when the item advances, which a stalled
//   receiver can hold back; out_valid_o then rises and holds until taken.
//   throughput: one item per cycle unless stalled; the whole pid update (three
//   16x11 products, a four-term add, clamp and duty lookup) sits between those
//   two registers. a stalled receiver holds the output register; the input
//   register still takes one more item, and in_ready_o drops only when both
//   stages are full. reset clears both stages, the prescaler and all control
//   history, and loads the default setpoint, gains and sample period.
//   configuration: cfg_we_i writes register cfg_index_i at the clock edge;
//   indexes past the sample period register are ignored. write while idle only.
module incremental_pid_heater_pwm (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration write port
  input  wire logic                              cfg_we_i,
  input  wire logic [ipid_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [ipid_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  // tick item in
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [ipid_pkg::TEMP_W-1:0]       temperature_i,
  input  wire logic                              oven_on_i,
  // result item out
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [ipid_pkg::DUTY_W-1:0]            duty_o,
  output logic [ipid_pkg::PWR_W-1:0]             power_percent_o,
  output logic                                   updated_o
);
  import ipid_pkg::*;

  // configuration registers
  logic [TEMP_W-1:0]        setpoint_q;
  logic signed [COEF_W-1:0] coef_now_q, coef_prev_q, coef_prev2_q;
  logic [PERIOD_W-1:0]      period_q;

  // input stage
  logic              in_vld_q;
  logic [TEMP_W-1:0] temp_q;
  logic              oven_q;

  // output stage
  logic              out_vld_q;
  logic [DUTY_W-1:0] duty_out_q;
  logic [PWR_W-1:0]  power_out_q;
  logic              upd_out_q;

  // control history
  logic [PERIOD_W-1:0]     tick_count_q;
  logic [TEMP_W-1:0]       last_reading_q;
  logic signed [ERR_W-1:0] error_prev_q, error_prev2_q;
  logic [EFFORT_W-1:0]     effort_prev_q;
  logic [DUTY_W-1:0]       duty_hold_q;
  logic [PWR_W-1:0]        power_hold_q;

  logic                    advance;
  logic [PERIOD_W-1:0]     tick_next;
  logic                    do_update;
  logic [TEMP_W-1:0]       sp_masked;
  logic signed [ERR_W-1:0] err_now;
  logic signed [PROD_W-1:0] prod_now, prod_prev, prod_prev2;
  logic signed [SUM_W-1:0] effort_sum;
  logic [EFFORT_W-1:0]     effort_d;
  logic [PWR_W-1:0]        power_raw;
  logic [DUTY_W-1:0]       duty_raw;
  logic [DUTY_W-1:0]       duty_hold_d;
  logic [PWR_W-1:0]        power_hold_d;

  // item moves from the input register to the output register
  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  // prescaler: a lowered period or a period of zero fires on the next tick
  assign tick_next = tick_count_q + PERIOD_W'(1);
  assign do_update = (tick_next >= period_q);

  // error against the reading of the previous item
  assign sp_masked = setpoint_q & TEMP_MASK;
  assign err_now   = $signed({1'b0, sp_masked}) - $signed({1'b0, last_reading_q});

  // three independent products, all with FRAC_BITS fraction bits
  assign prod_now   = PROD_W'(coef_now_q)   * PROD_W'(err_now);
  assign prod_prev  = PROD_W'(coef_prev_q)  * PROD_W'(error_prev_q);
  assign prod_prev2 = PROD_W'(coef_prev2_q) * PROD_W'(error_prev2_q);

  assign effort_sum = $signed({{(SUM_W-EFFORT_W){1'b0}}, effort_prev_q})
                    + SUM_W'(prod_now) + SUM_W'(prod_prev) + SUM_W'(prod_prev2);

  // clamp to 0..100 percent, zero setpoint forces zero effort
  always_comb begin
    priority if (effort_sum <= SUM_W'(0) || sp_masked == '0) begin
      effort_d = '0;
    end else if (effort_sum >= EFFORT_MAX_S) begin
      effort_d = EFFORT_MAX;
    end else begin
      effort_d = effort_sum[EFFORT_W-1:0];
    end
  end

  assign power_raw = effort_d[EFFORT_W-1 -: PWR_W];
  assign duty_raw  = DUTY_LUT[{power_raw, DUTY_SEL_SHIFT'(0)} +: DUTY_W];

  // held outputs change only on an update; an update with the oven off sets them to zero
  always_comb begin
    duty_hold_d  = duty_hold_q;
    power_hold_d = power_hold_q;
    if (do_update) begin
      duty_hold_d  = oven_q ? duty_raw  : '0;
      power_hold_d = oven_q ? power_raw : '0;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_q   <= SETPOINT_RST;
      coef_now_q   <= COEF_NOW_RST;
      coef_prev_q  <= COEF_PREV_RST;
      coef_prev2_q <= COEF_PREV2_RST;
      period_q     <= PERIOD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_SETPOINT:   setpoint_q   <= cfg_wdata_i[TEMP_W-1:0];
        REG_COEF_NOW:   coef_now_q   <= $signed(cfg_wdata_i[COEF_W-1:0]);
        REG_COEF_PREV:  coef_prev_q  <= $signed(cfg_wdata_i[COEF_W-1:0]);
        REG_COEF_PREV2: coef_prev2_q <= $signed(cfg_wdata_i[COEF_W-1:0]);
        REG_PERIOD:     period_q     <= cfg_wdata_i[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      temp_q <= temperature_i;
      oven_q <= oven_on_i;
    end
  end

  // control history advances once per item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_count_q   <= '0;
      last_reading_q <= '0;
      error_prev_q   <= '0;
      error_prev2_q  <= '0;
      effort_prev_q  <= '0;
      duty_hold_q    <= '0;
      power_hold_q   <= '0;
    end else if (advance) begin
      tick_count_q   <= do_update ? '0 : tick_next;
      last_reading_q <= temp_q & TEMP_MASK;
      duty_hold_q    <= duty_hold_d;
      power_hold_q   <= power_hold_d;
      if (do_update) begin
        error_prev2_q <= error_prev_q;
        error_prev_q  <= err_now;
        effort_prev_q <= effort_d;
      end
    end
  end

  // output stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      duty_out_q  <= duty_hold_d;
      power_out_q <= power_hold_d;
      upd_out_q   <= do_update;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign duty_o          = duty_out_q;
  assign power_percent_o = power_out_q;
  assign updated_o       = upd_out_q;

  // stored effort never leaves the clamp range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    effort_prev_q <= EFFORT_MAX)
    else $error("effort history out of range");

  // held power never exceeds full scale
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    power_hold_q <= PWR_W'(PCT_MAX))
    else $error("held power above full scale");

  // held duty always matches held power
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    duty_hold_q == DUTY_LUT[{power_hold_q, DUTY_SEL_SHIFT'(0)} +: DUTY_W])
    else $error("held duty disagrees with held power");

  // a waiting input item is neither lost nor altered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !advance) |=> (in_vld_q && $stable(temp_q) && $stable(oven_q)))
    else $error("input register overwritten while stalled");

  // the prescaler restarts on every update
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && do_update) |=> (tick_count_q == '0))
    else $error("tick count not cleared by update");

endmodule

`default_nettype wire
